// ===== design/bkts_pkg.sv =====
`timescale 1ns / 1ps
package bkts_pkg;

   localparam int MaxWord = 10;
   localparam int MaxDepth = 255;
   localparam int LengthBits = 16;
   localparam int NumKeywords = 36;

   // token length never saturates above 16 bits
   localparam int LenBits = (LengthBits < 16) ? LengthBits : 16;

   typedef logic [LenBits-1:0] len_type;
   typedef logic [$clog2(MaxDepth+1)-1:0] depth_type;
   typedef logic [$clog2(MaxWord+1)-1:0] wlen_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_BODY, PH_ESC, PH_GAP, PH_MODS, PH_SKIP, PH_CR, PH_WORD,
      PH_PAREN_SPACE, PH_PAREN, PH_DECL_SPACE, PH_DECL_COLON, PH_DECL_NAME
   } phase_type;

   typedef enum logic [1:0] {KW_CALL, KW_SPACED, KW_CLASS, KW_MODULE} kw_kind_type;

   localparam logic [2:0] KIND_TRANS = 3'd2;
   localparam logic [2:0] KIND_CALL = 3'd4;
   localparam logic [2:0] KIND_CLASS = 3'd5;
   localparam logic [2:0] KIND_MODULE = 3'd6;

   // keyword lookup result
   typedef struct packed {
      logic        hit;
      kw_kind_type kind;
   } kw_hit_type;

   typedef logic [MaxWord*7-1:0] word_type;

   function automatic logic [79:0] kw_text(input int i);
      case (i)
         0: kw_text = "all";         1: kw_text = "any";
         2: kw_text = "background";  3: kw_text = "case";
         4: kw_text = "chomp";       5: kw_text = "class";
         6: kw_text = "count";       7: kw_text = "default";
         8: kw_text = "delete";      9: kw_text = "deprecated";
         10: kw_text = "drop";       11: kw_text = "exists";
         12: kw_text = "final";      13: kw_text = "find";
         14: kw_text = "first";      15: kw_text = "foldl";
         16: kw_text = "foldr";      17: kw_text = "inherits";
         18: kw_text = "iterate";    19: kw_text = "map";
         20: kw_text = "module";     21: kw_text = "new";
         22: kw_text = "pop";        23: kw_text = "private";
         24: kw_text = "public";     25: kw_text = "push";
         26: kw_text = "returns";    27: kw_text = "select";
         28: kw_text = "shift";      29: kw_text = "splice";
         30: kw_text = "static";     31: kw_text = "take";
         32: kw_text = "takeuntil";  33: kw_text = "takewhile";
         34: kw_text = "trim";       default: kw_text = "unshift";
      endcase
   endfunction

   function automatic kw_kind_type kw_kind(input int i);
      case (i)
         5: kw_kind = KW_CLASS;
         20: kw_kind = KW_MODULE;
         7, 9, 24, 26, 30: kw_kind = KW_SPACED;
         default: kw_kind = KW_CALL;
      endcase
   endfunction

   function automatic logic is_wstart(input logic [7:0] c);
      is_wstart = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_kspace(input logic [7:0] c);
      is_kspace = c == " " || c == 8'h09 || c == 8'h0d;
   endfunction

endpackage

// ===== design/bkts_kw_match.sv =====
`timescale 1ns / 1ps
module bkts_kw_match (
   input  bkts_pkg::word_type   word,
   input  bkts_pkg::wlen_type   word_len,
   output bkts_pkg::kw_hit_type result
);
   import bkts_pkg::*;

   // compare the gathered word against every keyword in parallel;
   // both the word and the keyword text hold their last character lowest
   always_comb begin
      logic [79:0] t;
      logic        same;
      int          tl;
      result = '0;
      for (int i = 0; i < NumKeywords; i++) begin
         t = kw_text(i);
         tl = 0;
         for (int k = 0; k < 10; k++)
            if (t[k*8 +: 8] != 8'd0) tl = k + 1;
         same = (int'(word_len) == tl);
         for (int k = 0; k < 10; k++)
            if (k < tl && word[k*7 +: 7] != t[k*8 +: 7]) same = 1'b0;
         if (same && !result.hit) begin
            result.hit = 1'b1;
            result.kind = kw_kind(i);
         end
      end
   end
endmodule

// ===== design/brace_regex_and_keyword_token_scanner.sv =====
`timescale 1ns / 1ps
// A result is registered and appears in the cycle after the character that ends the scan.
// Throughput: one character per cycle while no result waits untaken; the next-state logic is
// a single pass over the scan state and the character, with the keyword compare done in parallel.
// A result that waits untaken stalls the input; a new transaction enters on the cycle it is taken.
// Reset: synchronous, active high; returns to idle with no pending result.
module brace_regex_and_keyword_token_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // start_req, valid_mask[8:1], ch[16:9], at_end[17]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // accepted, token_kind[3:1], token_length[19:4]
);
   import bkts_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  allowed_ff, allowed_in;
   logic [1:0]  rkind_ff, rkind_in;
   depth_type   depth_ff, depth_in;
   logic        second_ff, second_in;
   word_type    word_ff, word_in;
   wlen_type    wlen_ff, wlen_in;
   len_type     len_ff, len_in;
   logic [2:0]  decl_ff, decl_in;
   logic        vld_ff;
   logic [19:0] out_ff, out_in;
   logic        emit;
   kw_hit_type  kw;

   wire         take = req_tvalid && req_tready;
   wire         start = req_tdata[0];
   wire [7:0]   mask = req_tdata[8:1];
   wire         at_end = req_tdata[17];
   wire [7:0]   c = at_end ? 8'd0 : req_tdata[16:9];

   assign req_tready = !vld_ff || rsp_tready;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = {4'd0, out_ff};

   bkts_kw_match u_kw (.word(word_ff), .word_len(wlen_ff), .result(kw));

   always_comb begin
      logic [2:0]  n;
      logic        go, ok;
      logic [2:0]  kind;
      len_type     l;
      phase_type   p;
      phase_in = phase_ff; allowed_in = allowed_ff; rkind_in = rkind_ff;
      depth_in = depth_ff; second_in = second_ff; word_in = word_ff;
      wlen_in = wlen_ff; l = len_ff; decl_in = decl_ff;
      emit = 1'b0; ok = 1'b0; kind = '0;
      n = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);
      p = phase_ff;
      if (start) begin
         depth_in = depth_type'(1); second_in = 1'b0; wlen_in = '0; l = '0;
         if (n == 3'd1) begin
            allowed_in = mask; p = PH_BODY;
            rkind_in = mask[0] ? 2'd0 : mask[1] ? 2'd1 : mask[2] ? 2'd2 : 2'd3;
         end else begin
            allowed_in = (n == 3'd0) ? mask : (mask & 8'he0);
            rkind_in = '0; p = PH_SKIP;
         end
      end
      // the word phase only consults the registered word when no restart occurs
      go = 1'b1;
      for (int s = 0; s < 4; s++) begin
         if (go) begin
            go = 1'b0;
            case (p)
               PH_BODY: begin
                  if (at_end) emit = 1'b1;
                  else begin
                     if (l != '1) l = l + 1'b1;
                     if (c == "\\") p = PH_ESC;
                     else if (c == "{") begin
                        if (depth_in >= depth_type'(MaxDepth)) emit = 1'b1;
                        else depth_in = depth_in + 1'b1;
                     end else if (c == "}") begin
                        depth_in = depth_in - 1'b1;
                        if (depth_in == '0) begin
                           if ((rkind_in == 2'd1 || rkind_in == 2'd2) && !second_in)
                              p = PH_GAP;
                           else if (rkind_in == 2'd2) begin
                              emit = 1'b1; ok = 1'b1; kind = KIND_TRANS;
                           end else p = PH_MODS;
                        end
                     end
                  end
               end
               PH_ESC: begin
                  if (at_end) emit = 1'b1;
                  else begin
                     if (l != '1) l = l + 1'b1;
                     p = PH_BODY;
                  end
               end
               PH_GAP: begin
                  if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
                     if (l != '1) l = l + 1'b1;
                  end else if (c != "{") emit = 1'b1;
                  else begin
                     if (l != '1) l = l + 1'b1;
                     second_in = 1'b1; depth_in = depth_type'(1); p = PH_BODY;
                  end
               end
               PH_MODS: begin
                  if (c == "i" || c == "m" || c == "s" || c == "x" || c == "u" ||
                      c == "U" || (rkind_in != 2'd0 && c == "g")) begin
                     if (l != '1) l = l + 1'b1;
                  end else begin
                     emit = 1'b1; ok = 1'b1; kind = {1'b0, rkind_in};
                  end
               end
               PH_SKIP: begin
                  if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
                     if (allowed_in[7] && c == 8'h0a) emit = 1'b1;
                     else if (allowed_in[7] && c == 8'h0d) p = PH_CR;
                  end else if (!is_wstart(c)) emit = 1'b1;
                  else begin p = PH_WORD; go = 1'b1; end
               end
               PH_CR: begin
                  if (c == 8'h0a) emit = 1'b1;
                  else begin p = PH_SKIP; go = 1'b1; end
               end
               PH_WORD: begin
                  if (wlen_in != '0 && !(is_wstart(c) || (c >= "0" && c <= "9"))) begin
                     // wlen_in nonzero implies no restart, so kw reflects word_ff
                     l = len_type'(wlen_in);
                     if (!kw.hit) emit = 1'b1;
                     else if (kw.kind == KW_CALL || kw.kind == KW_SPACED) begin
                        if (!allowed_in[4]) emit = 1'b1;
                        else begin
                           p = (kw.kind == KW_SPACED) ? PH_PAREN_SPACE : PH_PAREN;
                           go = 1'b1;
                        end
                     end else begin
                        if (!(kw.kind == KW_CLASS ? allowed_in[5] : allowed_in[6]) ||
                            !is_kspace(c)) emit = 1'b1;
                        else begin
                           decl_in = (kw.kind == KW_CLASS) ? KIND_CLASS : KIND_MODULE;
                           p = PH_DECL_SPACE; go = 1'b1;
                        end
                     end
                  end else if (wlen_in >= wlen_type'(MaxWord)) emit = 1'b1;
                  else begin
                     word_in = {word_in[MaxWord*7-8:0], c[6:0]};
                     wlen_in = wlen_in + 1'b1;
                  end
               end
               PH_PAREN_SPACE: begin
                  if (!is_kspace(c)) begin p = PH_PAREN; go = 1'b1; end
               end
               PH_PAREN: begin
                  emit = 1'b1; ok = (c == "("); kind = KIND_CALL;
               end
               PH_DECL_SPACE: begin
                  if (!is_kspace(c)) begin
                     if (decl_in == KIND_CLASS && c == ":") p = PH_DECL_COLON;
                     else begin p = PH_DECL_NAME; go = 1'b1; end
                  end
               end
               PH_DECL_COLON: begin
                  if (c != ":") emit = 1'b1;
                  else p = PH_DECL_NAME;
               end
               PH_DECL_NAME: begin
                  emit = 1'b1; ok = is_wstart(c); kind = decl_in;
               end
               default: p = PH_IDLE;
            endcase
         end
      end
      phase_in = emit ? PH_IDLE : p;
      len_in = l;
      out_in = ok ? {16'(l), kind, 1'b1} : 20'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; allowed_ff <= '0; rkind_ff <= '0; depth_ff <= '0;
         second_ff <= 1'b0; wlen_ff <= '0; len_ff <= '0; decl_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         if (take && emit) vld_ff <= 1'b1;
         else if (rsp_tready) vld_ff <= 1'b0;
         if (take) begin
            phase_ff <= phase_in; allowed_ff <= allowed_in; rkind_ff <= rkind_in;
            depth_ff <= depth_in; second_ff <= second_in; wlen_ff <= wlen_in;
            len_ff <= len_in; decl_ff <= decl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) word_ff <= word_in;
      if (take && emit) out_ff <= out_in;
   end

   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      take && emit |=> phase_ff == PH_IDLE && rsp_tvalid) else $error("emit not idle");
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[19:1] == '0) else $error("reject fields");
   a_word_len: assert property (@(posedge clock) disable iff (reset)
      wlen_ff <= wlen_type'(MaxWord)) else $error("word overflow");
endmodule

// ===== bench/brace_regex_and_keyword_token_scanner_tb.sv =====
`timescale 1ns / 1ps
module brace_regex_and_keyword_token_scanner_tb;
   import bkts_pkg::*;

   localparam logic [2:0] KIND_MATCH = 3'd0;
   localparam logic [2:0] KIND_SUBST = 3'd1;
   localparam logic [2:0] KIND_EXTRACT = 3'd3;
   localparam logic [7:0] MASK_CALL = 8'h10;
   localparam logic [7:0] MASK_CLASS = 8'h20;
   localparam logic [7:0] MASK_MODULE = 8'h40;
   localparam logic [7:0] MASK_NEWLINE = 8'h80;
   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam int LenCap = 65535;

   typedef struct packed {
      logic       at_end;
      logic [7:0] ch;
      logic [7:0] mask;
      logic       start;
   } char_item_t;

   typedef struct packed {
      logic [15:0] length;
      logic [2:0]  kind;
      logic        accepted;
   } token_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [23:0] rsp_tdata;

   brace_regex_and_keyword_token_scanner dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   // scanner state mirror
   phase_type   sc_phase = PH_IDLE;
   logic [7:0]  sc_allow = '0;
   logic [2:0]  sc_rkind = '0;
   int          sc_depth = 0;
   bit          sc_second = 0;
   logic [6:0]  sc_word [MaxWord];
   int          sc_wlen = 0;
   int          sc_len = 0;
   logic [2:0]  sc_decl = '0;

   string kw_names [NumKeywords] = '{
      "all", "any", "background", "case", "chomp", "class", "count", "default",
      "delete", "deprecated", "drop", "exists", "final", "find", "first", "foldl",
      "foldr", "inherits", "iterate", "map", "module", "new", "pop", "private",
      "public", "push", "returns", "select", "shift", "splice", "static", "take",
      "takeuntil", "takewhile", "trim", "unshift"};

   char_item_t char_q [$];
   token_t     token_q [$];
   int errors = 0;
   int n_sent = 0;
   bit quiet = 0;
   bit rsp_hold = 0;

   function automatic bit id_start(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic bit id_char(logic [7:0] c);
      return id_start(c) || (c >= "0" && c <= "9");
   endfunction

   function automatic bit hspace(logic [7:0] c);
      return c == " " || c == 8'h09 || c == CH_CR;
   endfunction

   function automatic void bump_len();
      if (sc_len < LenCap) sc_len++;
   endfunction

   function automatic bit close_scan(bit ok, logic [2:0] kind, output token_t r);
      r.accepted = ok;
      r.kind = ok ? kind : 3'd0;
      r.length = ok ? sc_len[15:0] : 16'd0;
      sc_phase = PH_IDLE;
      return 1;
   endfunction

   // returns the keyword index, or -1
   function automatic int lookup_word();
      bit same;
      for (int i = 0; i < NumKeywords; i++) begin
         same = kw_names[i].len() == sc_wlen;
         for (int k = 0; k < sc_wlen && same; k++)
            if (kw_names[i][k] != {1'b0, sc_word[k]}) same = 0;
         if (same) return i;
      end
      return -1;
   endfunction

   function automatic kw_kind_type word_kind(string w);
      if (w == "class") return KW_CLASS;
      if (w == "module") return KW_MODULE;
      if (w == "default" || w == "deprecated" || w == "public" || w == "returns"
          || w == "static") return KW_SPACED;
      return KW_CALL;
   endfunction

   function automatic bit scan_char(char_item_t it, output token_t r);
      logic [7:0] c;
      int n, sel, idx;
      kw_kind_type kk;
      c = it.at_end ? 8'd0 : it.ch;
      r = '0;
      if (it.start) begin
         n = 0;
         sel = 0;
         for (int i = 0; i < 4; i++)
            if (it.mask[i]) begin
               if (n == 0) sel = i;
               n++;
            end
         sc_depth = 1;
         sc_second = 0;
         sc_wlen = 0;
         sc_len = 0;
         if (n == 1) begin
            sc_allow = it.mask;
            sc_rkind = sel[2:0];
            sc_phase = PH_BODY;
         end else begin
            sc_allow = (n == 0) ? it.mask : (it.mask & 8'he0);
            sc_rkind = KIND_MATCH;
            sc_phase = PH_SKIP;
         end
      end
      forever begin
         case (sc_phase)
            PH_BODY: begin
               if (it.at_end) return close_scan(0, 0, r);
               bump_len();
               if (c == "\\") sc_phase = PH_ESC;
               else if (c == "{") begin
                  if (sc_depth >= MaxDepth) return close_scan(0, 0, r);
                  sc_depth++;
               end else if (c == "}") begin
                  sc_depth--;
                  if (sc_depth == 0) begin
                     if ((sc_rkind == KIND_SUBST || sc_rkind == KIND_TRANS) && !sc_second)
                        sc_phase = PH_GAP;
                     else if (sc_rkind == KIND_TRANS) return close_scan(1, KIND_TRANS, r);
                     else sc_phase = PH_MODS;
                  end
               end
               return 0;
            end
            PH_ESC: begin
               if (it.at_end) return close_scan(0, 0, r);
               bump_len();
               sc_phase = PH_BODY;
               return 0;
            end
            PH_GAP: begin
               if (c == " " || c == 8'h09 || c == CH_CR || c == CH_LF) begin
                  bump_len();
                  return 0;
               end
               if (c != "{") return close_scan(0, 0, r);
               bump_len();
               sc_second = 1;
               sc_depth = 1;
               sc_phase = PH_BODY;
               return 0;
            end
            PH_MODS: begin
               if (c == "i" || c == "m" || c == "s" || c == "x" || c == "u" || c == "U"
                   || (sc_rkind != KIND_MATCH && c == "g")) begin
                  bump_len();
                  return 0;
               end
               return close_scan(1, sc_rkind, r);
            end
            PH_SKIP: begin
               if (c == " " || (c >= 9 && c <= 13)) begin
                  if (sc_allow[7] && c == CH_LF) return close_scan(0, 0, r);
                  if (sc_allow[7] && c == CH_CR) sc_phase = PH_CR;
                  return 0;
               end
               if (!id_start(c)) return close_scan(0, 0, r);
               sc_phase = PH_WORD;
            end
            PH_CR: begin
               if (c == CH_LF) return close_scan(0, 0, r);
               sc_phase = PH_SKIP;
            end
            PH_WORD: begin
               if (sc_wlen > 0 && !id_char(c)) begin
                  idx = lookup_word();
                  if (idx < 0) return close_scan(0, 0, r);
                  sc_len = sc_wlen;
                  kk = word_kind(kw_names[idx]);
                  if (kk == KW_CALL || kk == KW_SPACED) begin
                     if (!sc_allow[4]) return close_scan(0, 0, r);
                     sc_phase = (kk == KW_SPACED) ? PH_PAREN_SPACE : PH_PAREN;
                  end else begin
                     if (!sc_allow[kk == KW_CLASS ? 5 : 6] || !hspace(c))
                        return close_scan(0, 0, r);
                     sc_decl = (kk == KW_CLASS) ? KIND_CLASS : KIND_MODULE;
                     sc_phase = PH_DECL_SPACE;
                  end
               end else begin
                  if (sc_wlen >= MaxWord) return close_scan(0, 0, r);
                  sc_word[sc_wlen] = c[6:0];
                  sc_wlen++;
                  return 0;
               end
            end
            PH_PAREN_SPACE: begin
               if (hspace(c)) return 0;
               sc_phase = PH_PAREN;
            end
            PH_PAREN: return close_scan(c == "(", KIND_CALL, r);
            PH_DECL_SPACE: begin
               if (hspace(c)) return 0;
               if (sc_decl == KIND_CLASS && c == ":") begin
                  sc_phase = PH_DECL_COLON;
                  return 0;
               end
               sc_phase = PH_DECL_NAME;
            end
            PH_DECL_COLON: begin
               if (c != ":") return close_scan(0, 0, r);
               sc_phase = PH_DECL_NAME;
               return 0;
            end
            PH_DECL_NAME: return close_scan(id_start(c), sc_decl, r);
            default: begin
               sc_phase = PH_IDLE;
               return 0;
            end
         endcase
      end
   endfunction

   // queue one character; returns whether it ends a scan, with the predicted token in r
   function automatic bit put_char(bit st, logic [7:0] m, logic [7:0] c, bit e,
                                   output token_t r);
      char_item_t it;
      bit got;
      it = '{at_end: e, ch: c, mask: m, start: st};
      char_q.push_back(it);
      n_sent++;
      got = scan_char(it, r);
      return got;
   endfunction

   // a scan from text; optional at_end item at the tail
   function automatic void put_scan(logic [7:0] m, string s, bit tail_end,
                                    bit typed = 0, token_t want = '0);
      token_t r;
      bit got;
      for (int i = 0; i < s.len(); i++) begin
         got = put_char(i == 0, m, s[i], 0, r);
         if (got) token_q.push_back(typed ? want : r);
      end
      if (tail_end) begin
         got = put_char(s.len() == 0, m, 8'($urandom), 1, r);
         if (got) token_q.push_back(typed ? want : r);
      end
   endfunction

   function automatic byte pick(string set);
      return set[$urandom_range(set.len() - 1)];
   endfunction

   function automatic string body_text(int lvl);
      string s;
      int n;
      s = "";
      n = $urandom_range(6);
      for (int i = 0; i < n; i++)
         case ($urandom_range(9))
            0: s = {s, "\\", string'(pick("{}\\ax"))};
            1: if (lvl < 3) s = {s, "{", body_text(lvl + 1), "}"};
            default: s = {s, string'(pick("ab.*+?()[]^$ 09zZ|"))};
         endcase
      return s;
   endfunction

   function automatic string blank_text(string set);
      string s;
      s = "";
      repeat ($urandom_range(3)) s = {s, string'(pick(set))};
      return s;
   endfunction

   function automatic void random_regex();
      int k;
      string s, gap;
      k = $urandom_range(3);
      s = {body_text(0), "}"};
      if (k == 1 || k == 2) begin
         gap = "";
         if ($urandom_range(1) != 0) gap = " ";
         if ($urandom_range(3) == 0) gap = {gap, "\n\t\015"};
         s = {s, gap, "{", body_text(0), "}"};
      end
      if (k != 2) s = {s, blank_text("imsxuUg"), string'(pick(";, )g"))};
      if ($urandom_range(9) == 0) s = s.substr(0, $urandom_range(s.len() - 1));
      put_scan(8'(1 << k) | 8'($urandom_range(15) << 4), s, $urandom_range(7) == 0);
   endfunction

   function automatic void random_keyword();
      string s, w;
      logic [7:0] m;
      w = kw_names[$urandom_range(NumKeywords - 1)];
      case ($urandom_range(5))
         0: w = {w, string'(pick("sx_9"))};
         1: w = "takewhilex";
         2: w = "abcdefghijk";
         default: ;
      endcase
      s = {blank_text(" \t\015\n\013\014"), w};
      case ($urandom_range(4))
         0: s = {s, blank_text(" \t\015"), "("};
         1: s = {s, " ", blank_text(" \t"), string'(pick("Ab_:9"))};
         2: s = {s, " ::", string'(pick("Nz:1"))};
         3: s = {s, string'(pick("( .;"))};
         default: ;
      endcase
      m = 8'($urandom);
      if ($urandom_range(3) != 0) m[3:0] = 4'($urandom_range(1)) == 0 ? 4'h0 : 4'h3;
      put_scan(m, s, $urandom_range(5) == 0);
   endfunction

   function automatic void random_noise();
      token_t r;
      repeat ($urandom_range(1, 6))
         if (put_char($urandom_range(3) == 0, 8'($urandom), 8'($urandom),
                      $urandom_range(7) == 0, r))
            token_q.push_back(r);
   endfunction

   typedef struct {
      logic [7:0] mask;
      string      text;
      bit         tail_end;
      bit         typed;
      token_t     want;
   } row_t;

   row_t rows [] = '{
      '{8'h01, "ab}", 0, 0, '0},
      '{8'h01, "ab};", 0, 1, '{16'd3, KIND_MATCH, 1'b1}},
      '{8'h01, "", 1, 1, '0},
      '{8'h01, "a{b\\}c}}imsxuUg;", 0, 0, '0},
      '{8'h02, "x} \t\015\n{y}gi.", 0, 0, '0},
      '{8'h04, "a}{b}", 0, 1, '{16'd5, KIND_TRANS, 1'b1}},
      '{8'h04, "a} q", 0, 1, '0},
      '{8'h08, "\\{}U", 1, 0, '0},
      '{8'h01, "ab\\", 1, 1, '0},
      '{8'h10, "new(", 0, 1, '{16'd3, KIND_CALL, 1'b1}},
      '{8'h10, "  static \t (", 0, 0, '0},
      '{8'h20, "class Foo", 0, 1, '{16'd5, KIND_CLASS, 1'b1}},
      '{8'h20, "class ::x", 0, 0, '0},
      '{8'h40, "module m", 0, 1, '{16'd6, KIND_MODULE, 1'b1}},
      '{8'h80, " \n", 0, 1, '0},
      '{8'h80, "\015\n", 0, 1, '0},
      '{8'h80, "\015 new(", 0, 0, '0},
      '{8'hff, "class X", 0, 0, '0},
      '{8'h33, "new(", 0, 0, '0},
      '{8'h10, "takewhilexy(", 0, 0, '0},
      '{8'h10, "map", 1, 0, '0},
      '{8'h10, "9", 0, 1, '0}
   };

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (char_q.size() > 0 && (quiet || $urandom_range(99) >= 18)) begin
            req_tvalid <= 1;
            req_tdata <= {6'd0, char_q.pop_front()};
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= !rsp_hold && (quiet || $urandom_range(99) >= 18);
   end

   // long receiver hold-off, then a stretch with no idling on either side
   initial begin
      repeat (300) @(posedge clock);
      rsp_hold <= 1;
      repeat (400) @(posedge clock);
      rsp_hold <= 0;
      repeat (20) @(posedge clock);
      quiet <= 1;
      repeat (200) @(posedge clock);
      quiet <= 0;
   end

   always @(posedge clock) begin
      token_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[19:0];
         if (token_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected token %p", got);
         end else begin
            want = token_q.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("token mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("brace_regex_and_keyword_token_scanner_tb: FAIL");
      $finish;
   end

   initial begin
      string s;
      repeat (2) @(posedge clock);
      reset <= 0;
      foreach (rows[i]) put_scan(rows[i].mask, rows[i].text, rows[i].tail_end,
                                 rows[i].typed, rows[i].want);
      // nesting one past the bound
      s = "";
      repeat (MaxDepth + 1) s = {s, "{"};
      put_scan(8'h01, s, 0, 1, '0);
      while (n_sent < 700) begin
         case ($urandom_range(9))
            0, 1, 2, 3: random_regex();
            4, 5, 6, 7: random_keyword();
            default: random_noise();
         endcase
      end
      while (!(char_q.size() == 0 && !req_tvalid && token_q.size() == 0))
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && token_q.size() == 0) begin
         $display("brace_regex_and_keyword_token_scanner_tb: PASS");
      end else begin
         $display("brace_regex_and_keyword_token_scanner_tb: FAIL");
      end
      $finish;
   end

endmodule
